// ===== sv/pbr_pkg.sv =====
`default_nettype none
package pbr_pkg;

  localparam int MAX_COLS = 20;
  localparam int COL_W = 5;
  localparam int POS_W = 6;
  localparam int ROW_W = 2;

  localparam logic [7:0] GLYPH_OPEN  = 8'd91;
  localparam logic [7:0] GLYPH_FILL  = 8'd61;
  localparam logic [7:0] GLYPH_EMPTY = 8'd32;
  localparam logic [7:0] GLYPH_CLOSE = 8'd93;

  localparam logic [1:0] REG_MIN  = 2'd0;
  localparam logic [1:0] REG_MAX  = 2'd1;
  localparam logic [1:0] REG_COLS = 2'd2;
  localparam logic [1:0] REG_ROW  = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [COL_W-1:0] cols;
    logic [ROW_W-1:0] row;
  } cmd_t;

  typedef struct packed {
    logic [31:0]      min_value;
    logic [31:0]      max_value;
    logic [COL_W-1:0] num_cols;
    logic [ROW_W-1:0] row_index;
  } cfg_t;

endpackage
`default_nettype wire

// ===== sv/pbr_fifo.sv =====
`default_nettype none
module pbr_fifo
  import pbr_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  push,
  input  cmd_t din,
  input  wire  pop,
  output cmd_t dout,
  output logic full,
  output logic empty
);

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/pbr_front.sv =====
`default_nettype none
module pbr_front
  import pbr_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  cfg_t        cfg,
  input  wire  [31:0] value,
  input  wire         force_redraw,
  input  wire         in_valid,
  output logic        in_stall,
  output logic        push,
  output cmd_t        cmd,
  input  wire         full
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state;
  logic [31:0]      diff;
  logic [31:0]      range;
  logic [COL_W-1:0] cols;
  logic [COL_W-1:0] cells;
  logic             force_q;
  logic             at_min;
  logic             at_max;
  logic [38:0]      rem;
  logic [37:0]      dsh;
  logic [POS_W-1:0] quo;
  logic [2:0]       step;
  logic [POS_W-1:0] prev;
  logic [ROW_W-1:0] row_q;

  logic [COL_W-1:0] eff_cols;
  logic [36:0]      prod;
  logic             fits;
  logic             render;

  always_comb begin
    if (cfg.num_cols < COL_W'(2)) begin
      eff_cols = COL_W'(2);
    end else if (cfg.num_cols > COL_W'(MAX_COLS)) begin
      eff_cols = COL_W'(MAX_COLS);
    end else begin
      eff_cols = cfg.num_cols;
    end
  end

  assign prod     = 37'(diff) * 37'(cells);
  assign fits     = (rem >= {1'b0, dsh});
  assign render   = (quo != prev) || force_q;
  assign in_stall = (state != S_IDLE);
  assign push     = (state == S_DONE) && render && !full;
  assign cmd      = '{pos: quo, cols: cols, row: row_q};

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        diff    <= value - cfg.min_value;
        range   <= cfg.max_value - cfg.min_value;
        cols    <= eff_cols;
        cells   <= eff_cols - COL_W'(2);
        force_q <= force_redraw;
        at_min  <= (value <= cfg.min_value);
        at_max  <= (value >= cfg.max_value);
        row_q   <= cfg.row_index;
      end
      S_MUL: begin
        rem  <= {prod, 1'b0} + 39'(range);
        dsh  <= {range, 6'b0};
        step <= 3'd0;
        if (at_min) begin
          quo <= '0;
        end else if (at_max) begin
          quo <= POS_W'(cells);
        end else begin
          quo <= '0;
        end
      end
      S_DIV: begin
        if (fits) begin
          rem <= rem - {1'b0, dsh};
        end
        quo  <= {quo[POS_W-2:0], fits};
        dsh  <= dsh >> 1;
        step <= step + 3'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      prev  <= '1;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= (at_min || at_max) ? S_DONE : S_DIV;
        end
        S_DIV: begin
          if (step == 3'(POS_W - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!render) begin
            state <= S_IDLE;
          end else if (!full) begin
            prev  <= quo;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/pbr_back.sv =====
`default_nettype none
module pbr_back
  import pbr_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst,
  input  cmd_t                   cmd,
  input  wire                    empty,
  output logic                   pop,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic [ROW_W-1:0]       row,
  output logic [COL_W-1:0]       column,
  output logic [7:0]             char_code,
  output logic                   last
);

  cmd_t             cur;
  logic             busy;
  logic [COL_W-1:0] col;
  logic             advance;
  logic             is_end;
  logic [7:0]       glyph;

  assign advance = !out_valid || !out_stall;
  assign pop     = !busy && !empty;
  assign is_end  = (col == cur.cols - COL_W'(1));

  always_comb begin
    if (col == '0) begin
      glyph = GLYPH_OPEN;
    end else if (is_end) begin
      glyph = GLYPH_CLOSE;
    end else if (POS_W'(col) <= cur.pos) begin
      glyph = GLYPH_FILL;
    end else begin
      glyph = GLYPH_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= cmd;
    end
    if (busy && advance) begin
      row       <= cur.row;
      column    <= col;
      char_code <= glyph;
      last      <= is_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      col       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        col  <= '0;
      end else if (busy && advance) begin
        col <= col + COL_W'(1);
        if (is_end) begin
          busy <= 1'b0;
        end
      end
      if (advance) begin
        out_valid <= busy;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/progress_bar_row_renderer_unit.sv =====
// channel | direction | valid / stall          | payload
// input   | in        | in_valid / in_stall    | value, force_redraw
// output  | out       | out_valid / out_stall  | row, column, char_code, last
// config  | APB       | psel, penable, pready  | paddr, pwdata, prdata
//
// An item holds the input side through capture, one multiply,
// six restoring divide steps, then the redraw decision; the divide is
// skipped when the value is at or past either end of the range.
// A redraw emits the clamped column count of characters at one per cycle
// from the back end while out_stall is low, idle between rows; a two-entry
// queue of render commands lets the two halves stall apart.
// Output stall holds the character register; the front keeps taking items
// until both queue entries hold a row, then waits in its decision cycle.
// Synchronous reset; the stored position resets to all ones.
`default_nettype none
module progress_bar_row_renderer_unit
  import pbr_pkg::*;
(
  input  wire              clk,
  input  wire              rst,
  input  wire              psel,
  input  wire              penable,
  input  wire              pwrite,
  input  wire  [3:0]       paddr,
  input  wire  [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire  [31:0]      value,
  input  wire              force_redraw,
  input  wire              in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire              out_stall,
  output logic [ROW_W-1:0] row,
  output logic [COL_W-1:0] column,
  output logic [7:0]       char_code,
  output logic             last
);

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic push;
  logic pop;
  logic full;
  logic empty;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_value <= 32'd0;
      cfg.max_value <= 32'd100;
      cfg.num_cols  <= COL_W'(16);
      cfg.row_index <= '0;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        REG_MIN:  cfg.min_value <= pwdata;
        REG_MAX:  cfg.max_value <= pwdata;
        REG_COLS: cfg.num_cols  <= pwdata[COL_W-1:0];
        REG_ROW:  cfg.row_index <= pwdata[ROW_W-1:0];
        default:  cfg.row_index <= cfg.row_index;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MIN:  prdata = cfg.min_value;
      REG_MAX:  prdata = cfg.max_value;
      REG_COLS: prdata = 32'(cfg.num_cols);
      REG_ROW:  prdata = 32'(cfg.row_index);
      default:  prdata = '0;
    endcase
  end

  pbr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .value        (value),
    .force_redraw (force_redraw),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .push         (push),
    .cmd          (push_cmd),
    .full         (full)
  );

  pbr_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_cmd),
    .pop   (pop),
    .dout  (pop_cmd),
    .full  (full),
    .empty (empty)
  );

  pbr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (pop_cmd),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .row       (row),
    .column    (column),
    .char_code (char_code),
    .last      (last)
  );

  a_close_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> char_code == GLYPH_CLOSE)
    else $error("last character is not the closing bracket");

  a_open_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && column == '0 |-> char_code == GLYPH_OPEN && !last)
    else $error("first column is not the opening bracket");

  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("front end took a second transaction at once");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("render command pushed into a full queue");

endmodule
`default_nettype wire

// ===== bench/progress_bar_row_renderer_unit_test.sv =====
`timescale 1ns / 100ps
module progress_bar_row_renderer_unit_test;
  import pbr_pkg::*;

  localparam int IDLE_LIMIT    = 1000;
  localparam int SETTLE_CYCLES = 30;
  localparam int NUM_PHASES    = 8;
  localparam int RANDOM_ITEMS  = 12;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic [7:0]       code;
    logic             last;
  } glyph_t;

  class row_render_board;
    logic [31:0]      min_value;
    logic [31:0]      max_value;
    logic [COL_W-1:0] num_cols;
    logic [ROW_W-1:0] row_index;
    logic [POS_W-1:0] drawn_pos;
    glyph_t           glyphs_due[$];
    int               errors;
    int               rows_drawn;
    int               glyphs_seen;

    function new();
      min_value   = 32'd0;
      max_value   = 32'd100;
      num_cols    = COL_W'(16);
      row_index   = '0;
      drawn_pos   = '1;
      errors      = 0;
      rows_drawn  = 0;
      glyphs_seen = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_MIN:  min_value = data;
        REG_MAX:  max_value = data;
        REG_COLS: num_cols  = data[COL_W-1:0];
        REG_ROW:  row_index = data[ROW_W-1:0];
        default: ;
      endcase
    endfunction

    // Works out the bar position for one value and queues the row it draws.
    function void take_value(logic [31:0] v, logic f);
      int unsigned      cols;
      logic [POS_W-1:0] pos;
      logic [63:0]      span;
      logic [63:0]      num;
      glyph_t           g;
      cols = num_cols;
      if (cols < 2) cols = 2;
      if (cols > MAX_COLS) cols = MAX_COLS;
      pos = '0;
      if (v > min_value) begin
        if (v >= max_value) begin
          pos = POS_W'(cols - 2);
        end else begin
          span = {32'd0, max_value - min_value};
          num  = {32'd0, v - min_value} * 64'(cols - 2) * 64'd2 + span;
          pos  = POS_W'(num / (64'd2 * span));
        end
      end
      if (pos == drawn_pos && !f) return;
      drawn_pos = pos;
      rows_drawn++;
      for (int c = 0; c < cols; c++) begin
        g.row    = row_index;
        g.column = COL_W'(c);
        g.last   = (c == cols - 1);
        if (c == 0) g.code = GLYPH_OPEN;
        else if (c == cols - 1) g.code = GLYPH_CLOSE;
        else if (c <= pos) g.code = GLYPH_FILL;
        else g.code = GLYPH_EMPTY;
        glyphs_due.push_back(g);
      end
    endfunction

    function void check_glyph(glyph_t got);
      glyph_t want;
      glyphs_seen++;
      if (glyphs_due.size() == 0) begin
        $error("unexpected character: column %0d, code %0d", got.column, got.code);
        errors++;
        return;
      end
      want = glyphs_due.pop_front();
      if (got.row !== want.row) begin
        $error("row: expected %0d, got %0d", want.row, got.row);
        errors++;
      end
      if (got.column !== want.column) begin
        $error("column: expected %0d, got %0d", want.column, got.column);
        errors++;
      end
      if (got.code !== want.code) begin
        $error("char_code: expected %0d, got %0d", want.code, got.code);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [3:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic [31:0]      value = '0;
  logic             force_redraw = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] column;
  logic [7:0]       char_code;
  logic             last;

  row_render_board board = new();

  int burst_left = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int recv_tick = 0;
  int recv_mode = 0;
  int run_left = 0;
  bit stall_on = 1'b0;

  // register settings after the reset one: min, max, columns, row
  logic [31:0] phase_min  [NUM_PHASES-1] = '{32'd0, 32'd1000, 32'hFFFF_FFFF, 32'd500,
                                             32'h8000_0000, 32'd10, 32'd0};
  logic [31:0] phase_max  [NUM_PHASES-1] = '{32'hFFFF_FFFF, 32'd1000, 32'd0, 32'd200,
                                             32'h8000_0064, 32'd30, 32'd7};
  logic [31:0] phase_cols [NUM_PHASES-1] = '{32'd20, 32'd2, 32'd31, 32'd0,
                                             32'd1, 32'd21, 32'd9};
  logic [31:0] phase_row  [NUM_PHASES-1] = '{32'd3, 32'd1, 32'd2, 32'd0,
                                             32'd2, 32'd1, 32'd3};

  logic [31:0] first_vals [16] = '{32'd0, 32'd0, 32'd0, 32'd1, 32'd25, 32'd24, 32'd26,
                                   32'd50, 32'd99, 32'd100, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   32'd101, 32'h8000_0000, 32'd3, 32'd4};
  logic        first_force [16] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                                    1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                                    1'b1, 1'b0, 1'b0, 1'b0};

  progress_bar_row_renderer_unit dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_glyph(glyph_t'({row, column, char_code, last}));
  end

  // receiver: free-running, random single stalls, or long stall runs
  always @(posedge clk) begin
    if (!rst) begin
      recv_tick++;
      if (recv_tick % 64 == 0) recv_mode = $urandom_range(0, 2);
      case (recv_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: begin
          if (run_left == 0) begin
            stall_on = !stall_on;
            run_left = stall_on ? $urandom_range(1, 12) : $urandom_range(1, 6);
          end else begin
            run_left--;
          end
          out_stall <= stall_on;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [31:0] v, input logic f);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    value        <= v;
    force_redraw <= f;
    do @(posedge clk); while (in_stall);
    board.take_value(v, f);
    items_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_reg(idx, data);
  endtask

  // drain the row queue, then give the front end time to finish a silent item
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (board.glyphs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value(logic [31:0] prev);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(board.max_value, board.min_value);
      6: begin
        case ($urandom_range(0, 3))
          0: return board.min_value;
          1: return board.min_value + 32'd1;
          2: return board.max_value;
          default: return board.max_value - 32'd1;
        endcase
      end
      7: return $urandom();
      8: return prev;
      default: return $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
    endcase
  endfunction

  initial begin
    logic [31:0] last_v;
    last_v = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < 16; i++) send_item(first_vals[i], first_force[i]);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        settle();
        write_reg(REG_MIN, phase_min[ph-1]);
        write_reg(REG_MAX, phase_max[ph-1]);
        write_reg(REG_COLS, phase_cols[ph-1]);
        write_reg(REG_ROW, phase_row[ph-1]);
      end
      repeat (RANDOM_ITEMS) begin
        last_v = pick_value(last_v);
        send_item(last_v, $urandom_range(0, 4) == 0);
      end
    end
    settle();
    $display("%0d values sent over %0d register settings", items_sent, NUM_PHASES);
    $display("%0d rows drawn, %0d characters checked", board.rows_drawn, board.glyphs_seen);
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
